// ===== src/assert_macros.svh =====
// Assertion macros used by the checker file of the pulse encoder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define ASSERT_IMPLY(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("%m: implication check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("%m: next-cycle check failed");

`endif

// ===== src/lspe_pkg.sv =====
// Shared constants, codes and widths of the LED strip pulse encoder.
`timescale 1ns / 1ps

package lspe_pkg;

	localparam int PIXEL_COUNT = 8;
	localparam int PIX_W       = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;

	// Slot counts per frame for three- and four-byte pixels.
	localparam int DATA3  = PIXEL_COUNT * 24;
	localparam int DATA4  = PIXEL_COUNT * 32;
	localparam int TOTAL3 = DATA3 + 16 * 3;
	localparam int TOTAL4 = DATA4 + 16 * 4;
	localparam int SLOT_W = $clog2(TOTAL4 + 1);
	localparam int CHUNK_W = SLOT_W - 3;

	// Reciprocal of three for the byte number of three-byte pixels.
	localparam int RECIP3       = 43691;
	localparam int RECIP3_W     = 16;
	localparam int RECIP3_SHIFT = 17;

	localparam int BYTE_W = 8;
	localparam int DUTY_W = 8;
	localparam int OP_W   = 2;

	localparam logic [OP_W-1:0] OP_WRITE_ONE = 2'd0;
	localparam logic [OP_W-1:0] OP_WRITE_ALL = 2'd1;
	localparam logic [OP_W-1:0] OP_RENDER    = 2'd2;
	localparam logic [OP_W-1:0] OP_TICK      = 2'd3;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 8;
	localparam logic [CFG_IDX_W-1:0] REG_GREEN_SCALE   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BLUE_SCALE    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DUTY_ZERO     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DUTY_ONE      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_WHITE_CHANNEL = 3'd4;

	localparam logic [BYTE_W-1:0] GREEN_SCALE_RST = 8'hB0;
	localparam logic [BYTE_W-1:0] BLUE_SCALE_RST  = 8'hF0;
	localparam logic [DUTY_W-1:0] DUTY_ZERO_RST   = 8'd19;
	localparam logic [DUTY_W-1:0] DUTY_ONE_RST    = 8'd38;

endpackage

// ===== src/led_strip_pulse_encoder_unit.sv =====
// Top level of the LED strip pulse encoder: pixel store, slot sequencer, result register.
`timescale 1ns / 1ps

// Channel   Handshake             Payload
// input     in_valid / in_stall   op, pixel_index, red, green, blue, white
// output    out_valid / out_stall duty, line_active, frame_last
// config    cfg_write             cfg_index, cfg_data
//
// One beat per cycle unless in_stall holds it: a beat waits in the input register,
// where the store write, the frame control and the slot decode all happen, and a
// tick then leaves through the result register. Reset clears the pixel store, the
// frame state, the valid flags and the configuration registers to their defaults.
// in_stall rises only while a tick waits behind a stalled result.
module led_strip_pulse_encoder_unit
	import lspe_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [OP_W-1:0]       op,
	input  logic [7:0]            pixel_index,
	input  logic [BYTE_W-1:0]     red,
	input  logic [BYTE_W-1:0]     green,
	input  logic [BYTE_W-1:0]     blue,
	input  logic [BYTE_W-1:0]     white,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [DUTY_W-1:0]     duty,
	output logic                  line_active,
	output logic                  frame_last,
	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	// Configuration registers.
	logic [BYTE_W-1:0] green_scale_q;
	logic [BYTE_W-1:0] blue_scale_q;
	logic [DUTY_W-1:0] duty_zero_q;
	logic [DUTY_W-1:0] duty_one_q;
	logic              white_channel_q;

	// Input register.
	logic              valid_s1;
	logic [OP_W-1:0]   op_s1;
	logic [7:0]        index_s1;
	logic [BYTE_W-1:0] red_s1;
	logic [BYTE_W-1:0] green_s1;
	logic [BYTE_W-1:0] blue_s1;
	logic [BYTE_W-1:0] white_s1;

	// Frame state and pixel store.
	logic [31:0]       store_q [PIXEL_COUNT];
	logic [SLOT_W-1:0] slot_q;
	logic              busy_q;

	// Result register.
	logic              out_valid_q;
	logic [DUTY_W-1:0] duty_q;
	logic              active_q;
	logic              last_q;

	logic advance_s1;
	logic accept;

	// Hold a tick while the result register is full and stalled.
	assign advance_s1 = valid_s1 && ((op_s1 != OP_TICK) || !out_valid_q || !out_stall);
	assign in_stall   = valid_s1 && !advance_s1;
	assign accept     = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			green_scale_q   <= GREEN_SCALE_RST;
			blue_scale_q    <= BLUE_SCALE_RST;
			duty_zero_q     <= DUTY_ZERO_RST;
			duty_one_q      <= DUTY_ONE_RST;
			white_channel_q <= 1'b1;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_GREEN_SCALE:   green_scale_q   <= cfg_data[BYTE_W-1:0];
				REG_BLUE_SCALE:    blue_scale_q    <= cfg_data[BYTE_W-1:0];
				REG_DUTY_ZERO:     duty_zero_q     <= cfg_data[DUTY_W-1:0];
				REG_DUTY_ONE:      duty_one_q      <= cfg_data[DUTY_W-1:0];
				REG_WHITE_CHANNEL: white_channel_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	// Capture the payload of each accepted beat.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1    <= op;
			index_s1 <= pixel_index;
			red_s1   <= red;
			green_s1 <= green;
			blue_s1  <= blue;
			white_s1 <= white;
		end
	end

	// Colour word: scaled green, red, scaled blue, white from high byte down.
	logic [2*BYTE_W-1:0] green_prod;
	logic [2*BYTE_W-1:0] blue_prod;
	logic [31:0]         colour_word;
	logic                index_ok;

	assign green_prod  = green_s1 * green_scale_q;
	assign blue_prod   = blue_s1 * blue_scale_q;
	assign colour_word = {green_prod[2*BYTE_W-1:BYTE_W], red_s1,
		blue_prod[2*BYTE_W-1:BYTE_W], white_s1};
	assign index_ok    = {1'b0, index_s1} < 9'(PIXEL_COUNT);

	// Slot decode. The byte slot number splits into pixel and byte within it.
	logic [SLOT_W-1:0]            data_slots;
	logic [SLOT_W-1:0]            total_slots;
	logic [SLOT_W:0]              slot_inc;
	logic                         in_data;
	logic                         at_end;
	logic [CHUNK_W-1:0]           chunk;
	logic [CHUNK_W+RECIP3_W-1:0]  recip_prod;
	logic [PIX_W-1:0]             pix3;
	logic [CHUNK_W-1:0]           rem3;
	logic [PIX_W-1:0]             pix_sel;
	logic [1:0]                   byte_sel;
	logic [31:0]                  pix_word;
	logic [BYTE_W-1:0]            byte_val;
	logic                         data_bit;

	assign data_slots  = white_channel_q ? SLOT_W'(DATA4) : SLOT_W'(DATA3);
	assign total_slots = white_channel_q ? SLOT_W'(TOTAL4) : SLOT_W'(TOTAL3);
	assign slot_inc    = {1'b0, slot_q} + 1'b1;
	assign in_data     = slot_q < data_slots;
	assign at_end      = slot_inc >= {1'b0, total_slots};

	assign chunk      = slot_q[SLOT_W-1:3];
	assign recip_prod = chunk * RECIP3_W'(RECIP3);
	assign pix3       = recip_prod[RECIP3_SHIFT +: PIX_W];
	assign rem3       = chunk - CHUNK_W'(3 * recip_prod[CHUNK_W+RECIP3_W-1:RECIP3_SHIFT]);

	assign pix_sel  = white_channel_q ? chunk[2 +: PIX_W] : pix3;
	assign byte_sel = white_channel_q ? chunk[1:0] : rem3[1:0];
	assign pix_word = store_q[pix_sel];

	always_comb begin
		case (byte_sel)
			2'd0:    byte_val = pix_word[31:24];
			2'd1:    byte_val = pix_word[23:16];
			2'd2:    byte_val = pix_word[15:8];
			default: byte_val = pix_word[7:0];
		endcase
	end

	// MSB first: slot bit 0 sends byte bit 7.
	assign data_bit = byte_val[~slot_q[2:0]];

	// Apply writes and frame control as the beat leaves the input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PIXEL_COUNT; i++) begin
				store_q[i] <= '0;
			end
			slot_q <= '0;
			busy_q <= 1'b0;
		end else if (advance_s1) begin
			case (op_s1)
				OP_WRITE_ONE: begin
					if (index_ok) begin
						store_q[index_s1[PIX_W-1:0]] <= colour_word;
					end
				end
				OP_WRITE_ALL: begin
					for (int i = 0; i < PIXEL_COUNT; i++) begin
						store_q[i] <= colour_word;
					end
				end
				OP_RENDER: begin
					// Start when idle, abort when busy.
					busy_q <= !busy_q;
					slot_q <= '0;
				end
				OP_TICK: begin
					if (busy_q) begin
						if (in_data || !at_end) begin
							slot_q <= slot_inc[SLOT_W-1:0];
						end else begin
							slot_q <= '0;
							busy_q <= 1'b0;
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance_s1 && (op_s1 == OP_TICK)) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Load a result only for a tick; hold it while stalled.
	always_ff @(posedge clk) begin
		if (advance_s1 && (op_s1 == OP_TICK)) begin
			if (!busy_q) begin
				duty_q   <= '0;
				active_q <= 1'b0;
				last_q   <= 1'b0;
			end else begin
				duty_q   <= in_data ? (data_bit ? duty_one_q : duty_zero_q) : '0;
				active_q <= 1'b1;
				last_q   <= !in_data && at_end;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign duty        = duty_q;
	assign line_active = active_q;
	assign frame_last  = last_q;

endmodule

// ===== src/lspe_checker.sv =====
// Port-level checks of the LED strip pulse encoder and their bind.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lspe_checker
	import lspe_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_stall,
	input logic                  out_valid,
	input logic                  out_stall,
	input logic [DUTY_W-1:0]     duty,
	input logic                  line_active,
	input logic                  frame_last
);

	// Input back-pressure only comes from a stalled, full result register.
	`ASSERT_IMPLY(a_stall_cause, clk, arst_n, in_stall, out_valid && out_stall)
	// The final reset slot belongs to a running frame.
	`ASSERT_IMPLY(a_last_active, clk, arst_n, out_valid && frame_last, line_active)
	// Idle ticks carry no pulse.
	`ASSERT_IMPLY(a_idle_zero, clk, arst_n, out_valid && !line_active, duty == '0)
	// A stalled result holds.
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(duty) && $stable(line_active) && $stable(frame_last))

endmodule

bind led_strip_pulse_encoder_unit lspe_checker u_lspe_checker (.*);
